@@ sv/cts_pkg.sv @@
// Shared definitions for the cooperative task scheduler: item kinds,
// field widths and the command/status bundles between controller and datapath.
// No dependencies.
package cts_pkg;

	// Item kinds carried in s_tuser
	localparam logic [1:0] MODE_TICK     = 2'd0;
	localparam logic [1:0] MODE_ADD      = 2'd1;
	localparam logic [1:0] MODE_DISPATCH = 2'd2;
	localparam logic [1:0] MODE_CLEAR    = 2'd3;

	localparam int DEF_TASK_SLOTS = 8;
	localparam int RESULT_CAP     = 8;
	localparam int CNT_W          = $clog2(RESULT_CAP);
	localparam int SLOT_FW        = 3;
	localparam int WORD_W         = 16;
	localparam int PEND_W         = 8;
	localparam logic [PEND_W-1:0] PEND_MAX = '1;

	// Controller to datapath
	typedef struct packed {
		logic tick;       // advance every valid slot
		logic clear;      // free every slot
		logic add;        // fill first free slot, load add result
		logic empty;      // load the empty dispatch result
		logic take;       // consume scanned slot, load run result
		logic last;       // last flag for a run result
		logic scan_start; // point the scan at slot 0
		logic scan_adv;   // step the scan to the next slot
	} cts_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic any_pend;   // some slot has pending runs
		logic cur_pend;   // scanned slot has pending runs
		logic more_after; // a slot beyond the scanned one has pending runs
	} cts_stat_t;

endpackage

@@ sv/cts_datapath.sv @@
// Slot table, scan pointer and result register of the task scheduler.
// Depends on cts_pkg; driven by cts_ctrl through cts_cmd_t.
module cts_datapath import cts_pkg::*; #(
	parameter int TASK_SLOTS = DEF_TASK_SLOTS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cts_cmd_t          cmd,
	input  logic [WORD_W-1:0] in_handle,
	input  logic [WORD_W-1:0] in_delay,
	input  logic [WORD_W-1:0] in_period,
	output cts_stat_t         stat,
	output logic              res_accepted,
	output logic [SLOT_FW-1:0] res_slot,
	output logic [WORD_W-1:0] res_handle,
	output logic              res_run,
	output logic              res_last
);

	localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

	logic              valid_q   [TASK_SLOTS];
	logic [PEND_W-1:0] pending_q [TASK_SLOTS];
	logic [WORD_W-1:0] handle_q  [TASK_SLOTS];
	logic [WORD_W-1:0] delay_q   [TASK_SLOTS];
	logic [WORD_W-1:0] period_q  [TASK_SLOTS];
	logic [IW-1:0]     idx_q;

	logic [TASK_SLOTS-1:0] pend_vec;
	logic [TASK_SLOTS-1:0] after_m;
	logic [IW-1:0]         free_idx;
	logic                  full;

	// Pending map, free slot search and look-ahead for the scan
	always_comb begin
		free_idx = '0;
		full     = 1'b1;
		for (int j = TASK_SLOTS - 1; j >= 0; j--) begin
			pend_vec[j] = valid_q[j] && (pending_q[j] != '0);
			after_m[j]  = (j > int'(idx_q));
			if (!valid_q[j]) begin
				free_idx = IW'(j);
				full     = 1'b0;
			end
		end
	end

	assign stat.any_pend   = |pend_vec;
	assign stat.cur_pend   = pend_vec[idx_q];
	assign stat.more_after = |(pend_vec & after_m);

	// Control state of each slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TASK_SLOTS; i++) begin
				valid_q[i]   <= 1'b0;
				pending_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < TASK_SLOTS; i++) begin
				if (cmd.clear) begin
					valid_q[i]   <= 1'b0;
					pending_q[i] <= '0;
				end else if (cmd.tick) begin
					if (valid_q[i] && delay_q[i] == '0 && pending_q[i] != PEND_MAX) begin
						pending_q[i] <= pending_q[i] + 1'b1;
					end
				end else if (cmd.add && !full && free_idx == IW'(i)) begin
					valid_q[i]   <= 1'b1;
					pending_q[i] <= '0;
				end else if (cmd.take && idx_q == IW'(i)) begin
					if (period_q[i] == '0) begin
						valid_q[i]   <= 1'b0;
						pending_q[i] <= '0;
					end else begin
						pending_q[i] <= pending_q[i] - 1'b1;
					end
				end
			end
		end
	end

	// Task words of each slot
	always_ff @(posedge clk) begin
		for (int i = 0; i < TASK_SLOTS; i++) begin
			if (cmd.tick && valid_q[i]) begin
				if (delay_q[i] == '0) begin
					if (period_q[i] != '0) begin
						delay_q[i] <= period_q[i];
					end
				end else begin
					delay_q[i] <= delay_q[i] - 1'b1;
				end
			end else if (cmd.add && !full && free_idx == IW'(i)) begin
				handle_q[i] <= in_handle;
				delay_q[i]  <= in_delay;
				period_q[i] <= in_period;
			end
		end
	end

	// Scan pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.scan_start) begin
			idx_q <= '0;
		end else if (cmd.scan_adv) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.add) begin
			res_accepted <= !full;
			res_slot     <= full ? '0 : SLOT_FW'(free_idx);
			res_handle   <= '0;
			res_run      <= 1'b0;
			res_last     <= 1'b1;
		end else if (cmd.empty) begin
			res_accepted <= 1'b0;
			res_slot     <= '0;
			res_handle   <= '0;
			res_run      <= 1'b0;
			res_last     <= 1'b1;
		end else if (cmd.take) begin
			res_accepted <= 1'b0;
			res_slot     <= SLOT_FW'(idx_q);
			res_handle   <= handle_q[idx_q];
			res_run      <= 1'b1;
			res_last     <= cmd.last;
		end
	end

endmodule

@@ sv/cts_ctrl.sv @@
// Sequencer of the task scheduler: input handshake, dispatch scan and
// result valid flag. Depends on cts_pkg; commands cts_datapath.
module cts_ctrl import cts_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] in_mode,
	output logic       out_valid,
	input  logic       out_ready,
	input  cts_stat_t  stat,
	output cts_cmd_t   cmd,
	output logic       busy
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic             state_q;
	logic             state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             out_free;
	logic             accept;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) && out_free;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign busy      = (state_q == ST_SCAN);

	// Decode items and step the scan
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (in_mode)
						MODE_TICK:  cmd.tick  = 1'b1;
						MODE_ADD:   cmd.add   = 1'b1;
						MODE_CLEAR: cmd.clear = 1'b1;
						MODE_DISPATCH: begin
							if (stat.any_pend) begin
								cmd.scan_start = 1'b1;
								state_d        = ST_SCAN;
							end else begin
								cmd.empty = 1'b1;
							end
						end
						default: cmd = '0;
					endcase
				end
			end
			ST_SCAN: begin
				if (stat.cur_pend) begin
					if (out_free) begin
						cmd.take = 1'b1;
						cmd.last = !stat.more_after || cnt_q == CNT_W'(RESULT_CAP - 1);
						if (cmd.last) begin
							state_d = ST_IDLE;
						end else begin
							cmd.scan_adv = 1'b1;
						end
					end
				end else begin
					cmd.scan_adv = 1'b1;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State, result count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.scan_start) begin
				cnt_q <= '0;
			end else if (cmd.take) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.add || cmd.empty || cmd.take) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ sv/cooperative_task_scheduler.sv @@
// Time-triggered cooperative task scheduler, top level.
// Depends on cts_pkg, cts_ctrl and cts_datapath.
//
// Input channel s_*: s_tuser carries the item kind (tick, add, dispatch,
// clear); s_tdata carries handle, start delay and period for an add.
// Output channel m_*: one item per add, one per pending slot for a
// dispatch (at most eight, in slot order), or one empty item for a
// dispatch with nothing pending; m_tlast marks the final item.
// Tick and clear give no item. An add gives its item on the cycle after
// acceptance. A dispatch walks the slot table with one scan pointer, one
// slot per cycle unless a pending slot waits for the output register;
// the next item is accepted once the walk has ended.
// One result register sits on the output: an item is accepted while a
// result waits only if that result is taken in the same cycle. A stalled
// receiver holds the result; the walk still steps over idle slots and
// stops at the next slot with pending runs until the result is taken.
// Reset empties the table; no reset pass is needed.
module cooperative_task_scheduler import cts_pkg::*; #(
	parameter int TASK_SLOTS = DEF_TASK_SLOTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // task_handle[15:0], start_delay[31:16], repeat_period[47:32]
	input  logic [1:0]  s_tuser,  // mode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // accepted[0], slot[3:1], run_handle[19:4], run_now[20], zero
	output logic        m_tlast
);

	cts_cmd_t           cmd;
	cts_stat_t          stat;
	logic               busy;
	logic               res_accepted;
	logic [SLOT_FW-1:0] res_slot;
	logic [WORD_W-1:0]  res_handle;
	logic               res_run;

	cts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_mode   (s_tuser),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd),
		.busy      (busy)
	);

	cts_datapath #(
		.TASK_SLOTS (TASK_SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.in_handle    (s_tdata[15:0]),
		.in_delay     (s_tdata[31:16]),
		.in_period    (s_tdata[47:32]),
		.stat         (stat),
		.res_accepted (res_accepted),
		.res_slot     (res_slot),
		.res_handle   (res_handle),
		.res_run      (res_run),
		.res_last     (m_tlast)
	);

	assign m_tdata = {3'b000, res_run, res_handle, res_slot, res_accepted};

	// Consume only a slot that has pending runs
	a_take_pending: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |-> stat.cur_pend)
		else $error("slot consumed without pending runs");

	// A walk always has a pending slot to reach
	a_scan_pending: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> stat.any_pend)
		else $error("dispatch walk with no pending slot");

	// At most one result load per cycle
	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.add, cmd.empty, cmd.take}))
		else $error("two result loads in one cycle");

	// A run result never reports an add as accepted
	a_run_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[20]) |-> !m_tdata[0])
		else $error("run result with accepted set");

endmodule

@@ bench/cooperative_task_scheduler_test.sv @@
// Self-checking bench for cooperative_task_scheduler: drives tick, add, dispatch
// and clear items, predicts each result from a local copy of the slot table.
// Depends on cts_pkg and the cooperative_task_scheduler RTL.
`timescale 1ns / 100ps

module cooperative_task_scheduler_test;
	import cts_pkg::*;

	localparam int NSLOT = DEF_TASK_SLOTS;
	localparam int GAP_MAX = 18;
	localparam int HOLD_CYCLES = 300;

	// One input item plus its lead-in gap; sync marks a pause until all results are in
	typedef struct {
		logic [1:0]  mode;
		logic [15:0] handle;
		logic [15:0] delay;
		logic [15:0] period;
		int          gap;
		bit          sync;
	} sched_req_t;

	typedef struct packed {
		logic        accepted;
		logic [2:0]  slot;
		logic [15:0] run_handle;
		logic        run_now;
		logic        last;
	} sched_res_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;  // task_handle[15:0], start_delay[31:16], repeat_period[47:32]
	logic [1:0]  s_tuser = MODE_TICK;  // mode[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;  // accepted[0], slot[3:1], run_handle[19:4], run_now[20], zero
	logic        m_tlast;

	cooperative_task_scheduler i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// Local copy of the slot table
	logic              tbl_valid [NSLOT];
	logic [15:0]       tbl_handle[NSLOT];
	logic [15:0]       tbl_delay [NSLOT];
	logic [15:0]       tbl_period[NSLOT];
	logic [PEND_W-1:0] tbl_pend  [NSLOT];

	sched_req_t req_q[$];
	sched_res_t out_due[$];
	int         err_count = 0;
	int         items_taken = 0;
	int         results_seen = 0;
	int         hold_at = 0;
	logic       rx_hold = 1'b0;

	// Driver scratch
	sched_req_t cur_req;
	int         gap_left = 0;
	bit         gap_loaded = 0;
	// Receiver scratch
	int         stall_left = 0;
	sched_res_t got;

	function automatic void free_entry(int i);
		tbl_valid[i]  = 1'b0;
		tbl_handle[i] = '0;
		tbl_delay[i]  = '0;
		tbl_period[i] = '0;
		tbl_pend[i]   = '0;
	endfunction

	// Apply one accepted item to the table and queue the results it causes
	task automatic table_step(input sched_req_t rq);
		sched_res_t r;
		int         n;
		bit         found;
		n = 0;
		found = 0;
		r = '0;
		case (rq.mode)
			MODE_TICK: begin
				for (int i = 0; i < NSLOT; i++) begin
					if (tbl_valid[i]) begin
						if (tbl_delay[i] == 0) begin
							if (tbl_pend[i] != PEND_MAX)
								tbl_pend[i] = tbl_pend[i] + 1'b1;
							if (tbl_period[i] != 0)
								tbl_delay[i] = tbl_period[i];
						end else begin
							tbl_delay[i] = tbl_delay[i] - 1'b1;
						end
					end
				end
			end
			MODE_ADD: begin
				for (int i = 0; i < NSLOT; i++) begin
					if (!found && !tbl_valid[i]) begin
						found = 1;
						tbl_valid[i]  = 1'b1;
						tbl_handle[i] = rq.handle;
						tbl_delay[i]  = rq.delay;
						tbl_period[i] = rq.period;
						tbl_pend[i]   = '0;
						r.accepted = 1'b1;
						r.slot = i[2:0];
					end
				end
				r.last = 1'b1;
				out_due.push_back(r);
			end
			MODE_DISPATCH: begin
				for (int i = 0; i < NSLOT; i++) begin
					if (n < RESULT_CAP && tbl_valid[i] && tbl_pend[i] != 0) begin
						r = '0;
						r.slot = i[2:0];
						r.run_handle = tbl_handle[i];
						r.run_now = 1'b1;
						out_due.push_back(r);
						n++;
						tbl_pend[i] = tbl_pend[i] - 1'b1;
						if (tbl_period[i] == 0)
							free_entry(i);
					end
				end
				if (n == 0) begin
					r = '0;
					r.last = 1'b1;
					out_due.push_back(r);
				end else begin
					out_due[out_due.size() - 1].last = 1'b1;
				end
			end
			default: begin
				for (int i = 0; i < NSLOT; i++)
					free_entry(i);
			end
		endcase
	endtask

	task automatic report_mismatch(input string field, input int got_v, input int want_v);
		if (err_count < 30)
			$display("%0t: result %0d field %s got %0h want %0h",
				$realtime, results_seen, field, got_v, want_v);
		err_count++;
	endtask

	task automatic queue_item(input logic [1:0] mode, input logic [15:0] handle,
			input logic [15:0] delay, input logic [15:0] period, input int gap);
		sched_req_t rq;
		rq.mode = mode;
		rq.handle = handle;
		rq.delay = delay;
		rq.period = period;
		rq.gap = gap;
		rq.sync = 0;
		req_q.push_back(rq);
	endtask

	task automatic queue_sync();
		sched_req_t rq;
		rq = '{mode: MODE_TICK, handle: '0, delay: '0, period: '0, gap: 0, sync: 1};
		req_q.push_back(rq);
	endtask

	// Clock and reset
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		for (int i = 0; i < NSLOT; i++)
			free_entry(i);
	end

	// Fill the stimulus queue
	initial begin
		int         r;
		int         gap;
		int         taken;
		logic [1:0] mode;

		// Directed: empty table, handle zero, field extremes, full table
		queue_item(MODE_DISPATCH, 16'h0000, 16'h0000, 16'h0000, 0);
		queue_item(MODE_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
		queue_item(MODE_CLEAR, 16'h0000, 16'h0000, 16'h0000, 3);
		queue_item(MODE_ADD, 16'h0000, 16'h0000, 16'h0000, 0);
		queue_item(MODE_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
		queue_item(MODE_ADD, 16'h1234, 16'h0001, 16'h0001, 1);
		queue_item(MODE_ADD, 16'hA5A5, 16'h0000, 16'h0002, 0);
		queue_item(MODE_ADD, 16'h5A5A, 16'h0002, 16'h0000, 0);
		queue_item(MODE_ADD, 16'h0F0F, 16'h0003, 16'h0003, 2);
		queue_item(MODE_ADD, 16'hF0F0, 16'h0000, 16'h0001, 0);
		queue_item(MODE_ADD, 16'h8001, 16'h0001, 16'h0000, 0);
		queue_item(MODE_ADD, 16'h7FFE, 16'h0000, 16'h0000, 0);
		queue_item(MODE_DISPATCH, 16'h0000, 16'h0000, 16'h0000, 0);
		queue_item(MODE_TICK, 16'h0000, 16'h0000, 16'h0000, 0);
		queue_item(MODE_TICK, 16'h0000, 16'h0000, 16'h0000, 5);
		queue_item(MODE_DISPATCH, 16'h0000, 16'h0000, 16'h0000, 0);
		repeat (3) queue_item(MODE_TICK, 16'h0000, 16'h0000, 16'h0000, 0);
		queue_item(MODE_DISPATCH, 16'h0000, 16'h0000, 16'h0000, 0);
		queue_item(MODE_CLEAR, 16'h0000, 16'h0000, 16'h0000, 0);
		queue_item(MODE_DISPATCH, 16'h0000, 16'h0000, 16'h0000, 0);
		queue_item(MODE_ADD, 16'hBEEF, 16'h0000, 16'h0000, 0);
		queue_sync();

		// Every slot due at once: one dispatch gives eight results
		queue_item(MODE_CLEAR, 16'h0000, 16'h0000, 16'h0000, 0);
		for (int i = 0; i < NSLOT; i++)
			queue_item(MODE_ADD, 16'(16'h1000 + i), 16'h0000, 16'h0003, 0);
		queue_item(MODE_TICK, 16'h0000, 16'h0000, 16'h0000, 0);
		queue_item(MODE_DISPATCH, 16'h0000, 16'h0000, 16'h0000, 0);

		// Runs pile up: period 1 adds a run every other tick, dispatches drain them
		queue_item(MODE_CLEAR, 16'h0000, 16'h0000, 16'h0000, 0);
		queue_item(MODE_ADD, 16'hC3C3, 16'h0000, 16'h0001, 0);
		repeat (12) queue_item(MODE_TICK, 16'($urandom()), 16'($urandom()),
			16'($urandom()), 0);
		queue_sync();
		repeat (7) queue_item(MODE_DISPATCH, 16'h0000, 16'h0000, 16'h0000, 0);
		queue_item(MODE_CLEAR, 16'h0000, 16'h0000, 16'h0000, 0);
		queue_sync();

		// Random mix, mostly small delays and periods so runs come due
		taken = 0;
		foreach (req_q[k])
			if (!req_q[k].sync)
				taken++;
		hold_at = taken + 40;
		for (int k = 0; k < 195; k++) begin
			r = $urandom_range(0, 99);
			mode = (r < 35) ? MODE_TICK : (r < 65) ? MODE_ADD :
				(r < 95) ? MODE_DISPATCH : MODE_CLEAR;
			gap = ((k % 50) < 12) ? 0 : $urandom_range(0, GAP_MAX);
			queue_item(mode, 16'($urandom()),
				($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 3)),
				($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 4)),
				gap);
			if (k % 60 == 59)
				queue_sync();
		end
	end

	// Driver: present queued items, wait out each gap, pause on sync marks
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!(s_tvalid && !s_tready)) begin
			if (s_tvalid && s_tready) begin
				table_step(cur_req);
				items_taken++;
			end
			if (req_q.size() == 0) begin
				s_tvalid <= 1'b0;
			end else begin
				if (!gap_loaded) begin
					gap_left = req_q[0].gap;
					gap_loaded = 1;
				end
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (req_q[0].sync) begin
					if (out_due.size() == 0) begin
						void'(req_q.pop_front());
						gap_loaded = 0;
					end
					s_tvalid <= 1'b0;
				end else begin
					cur_req = req_q.pop_front();
					gap_loaded = 0;
					s_tdata <= {cur_req.period, cur_req.delay, cur_req.handle};
					s_tuser <= cur_req.mode;
					s_tvalid <= 1'b1;
				end
			end
		end
	end

	// Receiver: check each result against the oldest prediction, then maybe stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = {m_tdata[0], m_tdata[3:1], m_tdata[19:4], m_tdata[20], m_tlast};
				if (out_due.size() == 0) begin
					report_mismatch("unexpected", int'(got), 0);
				end else begin
					sched_res_t want;
					want = out_due.pop_front();
					if (got.accepted !== want.accepted)
						report_mismatch("accepted", int'(got.accepted),
							int'(want.accepted));
					if (got.slot !== want.slot)
						report_mismatch("slot", int'(got.slot), int'(want.slot));
					if (got.run_handle !== want.run_handle)
						report_mismatch("run_handle", int'(got.run_handle),
							int'(want.run_handle));
					if (got.run_now !== want.run_now)
						report_mismatch("run_now", int'(got.run_now), int'(want.run_now));
					if (got.last !== want.last)
						report_mismatch("last", int'(got.last), int'(want.last));
				end
				results_seen++;
				stall_left = ((results_seen / 32) % 3 == 1) ? 0 : $urandom_range(0, GAP_MAX);
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= !rx_hold;
			end
		end
	end

	// Long receiver hold-off while the sender keeps offering items
	initial begin
		@(posedge arst_n);
		@(posedge clk);
		while (hold_at == 0 || items_taken < hold_at)
			@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// Run end
	initial begin
		@(posedge arst_n);
		@(posedge clk);
		while (req_q.size() != 0 || s_tvalid || out_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (err_count == 0)
			$display("cooperative_task_scheduler_test OK");
		else
			$display("cooperative_task_scheduler_test NOT OK");
		$finish;
	end

	// Watchdog
	initial begin
		#10_000_000;
		$display("cooperative_task_scheduler_test NOT OK");
		$finish;
	end

endmodule
